FILE: sv/wsd_pkg.sv
// Package with shared types, codes and helpers for the WebSocket frame deframer.
package wsd_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ACT_TEXT  = 2'd0;
  localparam logic [1:0] ACT_PONG  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_UNSUP = 7'd127;

  localparam int KEY_BYTES = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       fin_flag;
    logic       last_of_frame;
    logic [1:0] frame_action;
  } res_t;

  function automatic logic [1:0] action_of(input logic [3:0] op);
    case (op)
      OP_TEXT:  action_of = ACT_TEXT;
      OP_PING:  action_of = ACT_PONG;
      OP_CLOSE: action_of = ACT_CLOSE;
      default:  action_of = ACT_NONE;
    endcase
  endfunction

endpackage

FILE: sv/wsd_parser.sv
// Frame parser: header, extended length, masking key and payload unmasking.
module wsd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  output wsd_pkg::res_t res
);
  import wsd_pkg::*;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT0    = 6'b000100,
    PH_EXT1    = 6'b001000,
    PH_KEY     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cur_opcode_r, cur_opcode_nxt;
  logic        cur_fin_r, cur_fin_nxt;
  logic        is_masked_r, is_masked_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [15:0] payload_length_r, payload_length_nxt;
  logic [15:0] payload_index_r, payload_index_nxt;
  logic [7:0]  mask_key_r [KEY_BYTES];
  logic [7:0]  mask_key_nxt [KEY_BYTES];

  logic [6:0]  len7;
  logic [15:0] ext_len;
  logic [15:0] idx_inc;
  logic [7:0]  unmasked;
  logic        last;

  assign len7     = rx_byte[6:0];
  assign ext_len  = {length_high_r, rx_byte};
  assign idx_inc  = payload_index_r + 16'd1;
  assign unmasked = is_masked_r ? (rx_byte ^ mask_key_r[payload_index_r[1:0]]) : rx_byte;
  assign last     = (idx_inc == payload_length_r);

  always_comb begin
    phase_nxt          = phase_r;
    cur_opcode_nxt     = cur_opcode_r;
    cur_fin_nxt        = cur_fin_r;
    is_masked_nxt      = is_masked_r;
    length_high_nxt    = length_high_r;
    payload_length_nxt = payload_length_r;
    payload_index_nxt  = payload_index_r;
    mask_key_nxt       = mask_key_r;
    res_valid          = 1'b0;
    res                = '0;
    res.frame_opcode   = cur_opcode_r;
    res.fin_flag       = cur_fin_r;
    if (in_fire) begin
      case (phase_r)
        PH_HDR0: begin
          cur_fin_nxt    = rx_byte[7];
          cur_opcode_nxt = rx_byte[3:0];
          phase_nxt      = PH_HDR1;
        end
        PH_HDR1: begin
          is_masked_nxt = rx_byte[7];
          if (len7 == LEN_UNSUP) begin
            phase_nxt         = PH_HDR0;
            res_valid         = 1'b1;
            res.kind          = KIND_ERROR;
            res.last_of_frame = 1'b1;
            res.frame_action  = ACT_CLOSE;
          end else if (len7 == LEN_EXT16) begin
            phase_nxt = PH_EXT0;
          end else begin
            payload_length_nxt = {9'd0, len7};
            payload_index_nxt  = '0;
            if (rx_byte[7]) begin
              phase_nxt = PH_KEY;
            end else if (len7 == 7'd0) begin
              phase_nxt         = PH_HDR0;
              res_valid         = 1'b1;
              res.kind          = KIND_EMPTY;
              res.last_of_frame = 1'b1;
              res.frame_action  = action_of(cur_opcode_r);
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_EXT0: begin
          length_high_nxt = rx_byte;
          phase_nxt       = PH_EXT1;
        end
        PH_EXT1: begin
          payload_length_nxt = ext_len;
          payload_index_nxt  = '0;
          if (is_masked_r) begin
            phase_nxt = PH_KEY;
          end else if (ext_len == 16'd0) begin
            phase_nxt         = PH_HDR0;
            res_valid         = 1'b1;
            res.kind          = KIND_EMPTY;
            res.last_of_frame = 1'b1;
            res.frame_action  = action_of(cur_opcode_r);
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_KEY: begin
          mask_key_nxt[payload_index_r[1:0]] = rx_byte;
          if (payload_index_r[1:0] == 2'(KEY_BYTES - 1)) begin
            payload_index_nxt = '0;
            if (payload_length_r == 16'd0) begin
              phase_nxt         = PH_HDR0;
              res_valid         = 1'b1;
              res.kind          = KIND_EMPTY;
              res.last_of_frame = 1'b1;
              res.frame_action  = action_of(cur_opcode_r);
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end else begin
            payload_index_nxt = idx_inc;
          end
        end
        PH_PAYLOAD: begin
          payload_index_nxt = idx_inc;
          if (last) begin
            phase_nxt = PH_HDR0;
          end
          res_valid         = 1'b1;
          res.kind          = KIND_PAYLOAD;
          res.data_byte     = unmasked;
          res.last_of_frame = last;
          res.frame_action  = last ? action_of(cur_opcode_r) : ACT_TEXT;
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HDR0;
      cur_opcode_r     <= '0;
      cur_fin_r        <= 1'b0;
      is_masked_r      <= 1'b0;
      length_high_r    <= '0;
      payload_length_r <= '0;
      payload_index_r  <= '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
        mask_key_r[i] <= '0;
      end
    end else begin
      phase_r          <= phase_nxt;
      cur_opcode_r     <= cur_opcode_nxt;
      cur_fin_r        <= cur_fin_nxt;
      is_masked_r      <= is_masked_nxt;
      length_high_r    <= length_high_nxt;
      payload_length_r <= payload_length_nxt;
      payload_index_r  <= payload_index_nxt;
      mask_key_r       <= mask_key_nxt;
    end
  end

  // key position stays inside the key while collecting it
  a_key_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KEY) |-> (payload_index_r < 16'(KEY_BYTES)))
    else $error("key index out of range");
  // payload never runs past its length
  a_pay_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (payload_index_r < payload_length_r))
    else $error("payload index past length");
  // a frame close always returns to header parsing
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last_of_frame) |=> (phase_r == PH_HDR0))
    else $error("frame end without return to header");

endmodule

FILE: sv/wsd_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module wsd_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsd_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output wsd_pkg::res_t out_data
);
  import wsd_pkg::*;

  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic pop;

  assign pop       = out_valid_r & out_ready;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!out_valid_nxt) begin
        out_nxt       = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // skid entry only exists behind a held output
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid valid without output valid");
  // no push into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("push while full");
  // a stalled skid entry is moved forward when the output drains
  a_skid_move: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && skid_valid_r && !push) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry lost");

endmodule

FILE: sv/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer.
// A result is registered in the output buffer before it appears on out_*, and waits there while out_ready is low.
// Throughput: one byte per cycle while in_ready is high; the parser state updates in a single registered step.
// A two-entry result buffer keeps input flowing while one result waits on out_ready.
// Reset (rst_n low, synchronous) returns the parser to the first header byte, empties the
// buffer and clears opcode, flags, lengths and masking key.
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [3:0] out_frame_opcode,
  output logic       out_fin_flag,
  output logic       out_last_of_frame,
  output logic [1:0] out_frame_action
);
  import wsd_pkg::*;

  logic in_fire;
  logic res_valid;
  res_t res;
  logic buf_full;
  res_t out_data;

  assign in_ready = !buf_full;
  assign in_fire  = in_valid & in_ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind          = out_data.kind;
  assign out_data_byte     = out_data.data_byte;
  assign out_frame_opcode  = out_data.frame_opcode;
  assign out_fin_flag      = out_data.fin_flag;
  assign out_last_of_frame = out_data.last_of_frame;
  assign out_frame_action  = out_data.frame_action;

  a_act_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_frame) |-> (out_frame_action == ACT_TEXT))
    else $error("action outside frame end");
  a_nonpayload_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_PAYLOAD) |-> (out_last_of_frame && out_data_byte == 8'd0))
    else $error("non-payload result not closing frame");
  a_error_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ERROR) |-> (out_frame_action == ACT_CLOSE))
    else $error("length error without close action");

endmodule

FILE: sim/websocket_frame_deframer_tb.sv
// Self-checking testbench for the WebSocket frame deframer: directed frames, then random streams.
module websocket_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  localparam int CALM_ITEMS     = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum logic [2:0] {
    PH_HEADER0, PH_HEADER1, PH_EXTLEN_HI, PH_EXTLEN_LO, PH_MASK_KEY, PH_PAYLOAD
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    res_t       want;
  } stim_row_t;

  localparam res_t NO_RESULT = '0;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic [3:0] out_frame_opcode;
  logic       out_fin_flag;
  logic       out_last_of_frame;
  logic [1:0] out_frame_action;

  websocket_frame_deframer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_frame_opcode  (out_frame_opcode),
    .out_fin_flag      (out_fin_flag),
    .out_last_of_frame (out_last_of_frame),
    .out_frame_action  (out_frame_action)
  );

  // parser shadow state
  parse_phase_t parse_phase = PH_HEADER0;
  logic [3:0]   frame_op = '0;
  logic         frame_fin = 1'b0;
  logic         frame_masked = 1'b0;
  logic [7:0]   len_high = '0;
  logic [15:0]  frame_len = '0;
  logic [15:0]  byte_idx = '0;
  logic [7:0]   key_bytes [KEY_BYTES] = '{default: 8'h00};

  res_t      pending_results[$];
  stim_row_t directed_rows[$];
  int        items_sent = 0;
  int        mismatches = 0;
  int        idle_pct = 15;
  int        stall_left = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [1:0] frame_action_for(input logic [3:0] op);
    case (op)
      OP_TEXT:  return ACT_TEXT;
      OP_PING:  return ACT_PONG;
      OP_CLOSE: return ACT_CLOSE;
      default:  return ACT_NONE;
    endcase
  endfunction

  task automatic close_header(output bit produced, output res_t r);
    produced = 1'b0;
    r = NO_RESULT;
    byte_idx = '0;
    if (frame_masked) begin
      parse_phase = PH_MASK_KEY;
    end else if (frame_len == 0) begin
      parse_phase = PH_HEADER0;
      produced = 1'b1;
      r = {KIND_EMPTY, 8'h00, frame_op, frame_fin, 1'b1, frame_action_for(frame_op)};
    end else begin
      parse_phase = PH_PAYLOAD;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit produced, output res_t r);
    logic [7:0] d;
    logic       last;
    produced = 1'b0;
    r = NO_RESULT;
    case (parse_phase)
      PH_HEADER0: begin
        frame_fin = b[7];
        frame_op = b[3:0];
        parse_phase = PH_HEADER1;
      end
      PH_HEADER1: begin
        frame_masked = b[7];
        if (b[6:0] == LEN_UNSUP) begin
          parse_phase = PH_HEADER0;
          produced = 1'b1;
          r = {KIND_ERROR, 8'h00, frame_op, frame_fin, 1'b1, ACT_CLOSE};
        end else if (b[6:0] == LEN_EXT16) begin
          parse_phase = PH_EXTLEN_HI;
        end else begin
          frame_len = {9'd0, b[6:0]};
          close_header(produced, r);
        end
      end
      PH_EXTLEN_HI: begin
        len_high = b;
        parse_phase = PH_EXTLEN_LO;
      end
      PH_EXTLEN_LO: begin
        frame_len = {len_high, b};
        close_header(produced, r);
      end
      PH_MASK_KEY: begin
        key_bytes[byte_idx[1:0]] = b;
        byte_idx = byte_idx + 16'd1;
        if (byte_idx >= KEY_BYTES) begin
          byte_idx = '0;
          if (frame_len == 0) begin
            parse_phase = PH_HEADER0;
            produced = 1'b1;
            r = {KIND_EMPTY, 8'h00, frame_op, frame_fin, 1'b1, frame_action_for(frame_op)};
          end else begin
            parse_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        d = frame_masked ? (b ^ key_bytes[byte_idx[1:0]]) : b;
        byte_idx = byte_idx + 16'd1;
        last = (byte_idx == frame_len);
        if (last) parse_phase = PH_HEADER0;
        produced = 1'b1;
        r = {KIND_PAYLOAD, d, frame_op, frame_fin, last,
             last ? frame_action_for(frame_op) : 2'b00};
      end
      default: parse_phase = PH_HEADER0;
    endcase
  endtask

  task automatic add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // entered and left at a falling edge; valid stays up after acceptance until the caller
  // drives the next item or drops it
  task automatic send_row(input stim_row_t row);
    bit   produced;
    res_t r;
    calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= row.rx;
    do @(posedge clk); while (!in_ready);
    deframe_byte(row.rx, produced, r);
    if (produced) pending_results.insert(pending_results.size(), row.typed ? row.want : r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none actual kind %0d data %02h", $time, out_kind,
                 out_data_byte);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", int'(want.kind), int'(out_kind));
        check_field("data_byte", int'(want.data_byte), int'(out_data_byte));
        check_field("frame_opcode", int'(want.frame_opcode), int'(out_frame_opcode));
        check_field("fin_flag", int'(want.fin_flag), int'(out_fin_flag));
        check_field("last_of_frame", int'(want.last_of_frame), int'(out_last_of_frame));
        check_field("frame_action", int'(want.frame_action), int'(out_frame_action));
      end
    end
  end

  always @(negedge clk) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 99) < idle_pct)
      stall_left = $urandom_range(1, 18);
    if (calm) stall_left = 0;
    out_ready <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  hdr0;
    logic [7:0]  rnd;
    logic [3:0]  op;
    logic [15:0] flen;
    bit          masked;
    bit          paused;
    int          sel;

    paused = 1'b0;
    // empty text frame straight after reset
    add_row({8'h81, 1'b0, NO_RESULT});
    add_row({8'h00, 1'b1, KIND_EMPTY, 8'h00, OP_TEXT, 1'b1, 1'b1, ACT_TEXT});
    // unsupported length with the mask bit set
    add_row({8'h0F, 1'b0, NO_RESULT});
    add_row({8'hFF, 1'b1, KIND_ERROR, 8'h00, 4'hF, 1'b0, 1'b1, ACT_CLOSE});
    // masked ping, two payload bytes
    add_row({8'hF9, 1'b0, NO_RESULT});
    add_row({8'h82, 1'b0, NO_RESULT});
    add_row({8'hFF, 1'b0, NO_RESULT});
    add_row({8'h00, 1'b0, NO_RESULT});
    add_row({8'hA5, 1'b0, NO_RESULT});
    add_row({8'h5A, 1'b0, NO_RESULT});
    add_row({8'hFF, 1'b0, NO_RESULT});
    add_row({8'hFF, 1'b0, NO_RESULT});
    // close frame with 16-bit length of one
    add_row({8'h88, 1'b0, NO_RESULT});
    add_row({8'h7E, 1'b0, NO_RESULT});
    add_row({8'h00, 1'b0, NO_RESULT});
    add_row({8'h01, 1'b0, NO_RESULT});
    add_row({8'h00, 1'b0, NO_RESULT});
    // masked empty frame with an ignored opcode
    add_row({8'h02, 1'b0, NO_RESULT});
    add_row({8'h80, 1'b0, NO_RESULT});
    add_row({8'h12, 1'b0, NO_RESULT});
    add_row({8'h34, 1'b0, NO_RESULT});
    add_row({8'h56, 1'b0, NO_RESULT});
    add_row({8'h78, 1'b0, NO_RESULT});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_row(directed_rows[i]);
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 5;
        default: idle_pct = 25;
      endcase

      if ($urandom_range(0, 99) < 8) begin
        // noise, then random bytes until the parser is back at a header
        repeat ($urandom_range(1, 3)) begin
          rnd = 8'($urandom_range(0, 255));
          send_row({rnd, 1'b0, NO_RESULT});
        end
        while (parse_phase != PH_HEADER0) begin
          rnd = (parse_phase == PH_EXTLEN_HI) ? 8'($urandom_range(0, 1))
                                              : 8'($urandom_range(0, 255));
          send_row({rnd, 1'b0, NO_RESULT});
        end
      end else begin
        case ($urandom_range(0, 5))
          0:       op = OP_TEXT;
          1:       op = OP_PING;
          2:       op = OP_CLOSE;
          default: op = 4'($urandom_range(0, 15));
        endcase
        hdr0 = 8'($urandom_range(0, 255));
        hdr0[3:0] = op;
        masked = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        send_row({hdr0, 1'b0, NO_RESULT});
        if (sel < 6) begin
          send_row({masked, LEN_UNSUP, 1'b0, NO_RESULT});
        end else begin
          if (sel < 18) begin
            flen = ($urandom_range(0, 29) == 0) ? 16'(256 + $urandom_range(0, 60))
                                                : 16'($urandom_range(0, 40));
            send_row({masked, LEN_EXT16, 1'b0, NO_RESULT});
            send_row({flen[15:8], 1'b0, NO_RESULT});
            send_row({flen[7:0], 1'b0, NO_RESULT});
          end else begin
            flen = (sel < 26) ? 16'($urandom_range(0, 125)) : 16'($urandom_range(0, 10));
            send_row({masked, flen[6:0], 1'b0, NO_RESULT});
          end
          if (masked) begin
            repeat (KEY_BYTES) begin
              rnd = 8'($urandom_range(0, 255));
              send_row({rnd, 1'b0, NO_RESULT});
            end
          end
          repeat (flen) begin
            rnd = 8'($urandom_range(0, 255));
            send_row({rnd, 1'b0, NO_RESULT});
          end
        end
      end

      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
